### rtl/rbd_pkg.sv
// ============================================================================
// rbd_pkg - shared types and constants for the ring buffer deque
// Operation and status codes, stream field widths, result record layout.
// ============================================================================
package rbd_pkg;

    localparam int FUNC_BITS    = 2;
    localparam int JOB_BITS     = 32;
    localparam int CNT_BITS     = 9;
    localparam int S_TDATA_BITS = 40;
    localparam int M_TDATA_BITS = 48;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_POP_FRONT  = 2'd1,
        FUNC_PUSH_BACK  = 2'd2,
        FUNC_POP_BACK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // packed MSB first: status ends up in the lowest bits
    typedef struct packed {
        logic                is_full;
        logic                is_empty;
        logic [CNT_BITS-1:0] entry_count;
        logic [JOB_BITS-1:0] job_out;
        status_t             status;
    } res_t;

    localparam int RES_BITS = $bits(res_t);

    // controller -> datapath
    typedef struct packed {
        logic exec;          // input transfer, run the operation
        logic produce;       // result of the last operation is ready to load
        logic out_ld;        // load output register
        logic out_sel_skid;  // output register takes the skid entry
        logic skid_ld;       // load skid register with the new result
    } cmd_t;

endpackage

### rtl/rbd_ctrl.sv
// ============================================================================
// rbd_ctrl - ring buffer deque controller
// Two-state sequencer plus output/skid occupancy tracking.
// ============================================================================
module rbd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output rbd_pkg::cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    logic   m_xfer;

    assign s_tready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_xfer   = out_valid_reg && m_tready;

    always_comb begin
        cmd              = '0;
        cmd.exec         = s_tvalid && s_tready;
        cmd.produce      = (state_reg == S_DONE);
        state_next       = state_reg;
        out_valid_next   = (out_valid_reg && !m_xfer) || skid_valid_reg || cmd.produce;
        skid_valid_next  = skid_valid_reg;

        unique case (state_reg)
            S_IDLE: if (cmd.exec) state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase

        if (m_xfer && skid_valid_reg) begin
            cmd.out_ld       = 1'b1;
            cmd.out_sel_skid = 1'b1;
            cmd.skid_ld      = cmd.produce;
            skid_valid_next  = cmd.produce;
        end else if (cmd.produce && (!out_valid_reg || m_xfer)) begin
            cmd.out_ld = 1'b1;
        end else if (cmd.produce) begin
            cmd.skid_ld     = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

endmodule

### rtl/rbd_datapath.sv
// ============================================================================
// rbd_datapath - ring buffer deque datapath
// Slot memory, front/back pointers, entry count and result registers.
// ============================================================================
module rbd_datapath #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rbd_pkg::cmd_t                  cmd,
    input  rbd_pkg::func_t                 func,
    input  logic [rbd_pkg::JOB_BITS-1:0]   job_in,
    output rbd_pkg::res_t                  res_out
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_BITS-1:0] slot_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [PW-1:0] front_reg, front_next;
    logic [PW-1:0] back_reg, back_next;
    logic [CW-1:0] count_reg, count_next;
    rbd_pkg::status_t status_reg, status_next;
    logic          pop_ok_reg, pop_ok_next;

    logic [PW-1:0] front_up, front_dn, back_up, back_dn;
    logic [PW-1:0] wr_addr, rd_addr;
    logic          wr_en, rd_en;
    logic          full, empty;

    rbd_pkg::res_t res_new, out_reg, skid_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_up = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dn = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign back_up  = (back_reg == PW'(DEPTH - 1)) ? '0 : back_reg + 1'b1;
    assign back_dn  = (back_reg == '0) ? PW'(DEPTH - 1) : back_reg - 1'b1;

    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = rbd_pkg::ST_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = back_reg;
        rd_addr     = front_reg;

        unique case (func)
            rbd_pkg::FUNC_PUSH_FRONT, rbd_pkg::FUNC_PUSH_BACK: begin
                if (full) begin
                    status_next = rbd_pkg::ST_FULL;
                end else begin
                    wr_en      = cmd.exec;
                    count_next = count_reg + 1'b1;
                    if (func == rbd_pkg::FUNC_PUSH_FRONT) begin
                        wr_addr    = front_dn;
                        front_next = front_dn;
                    end else begin
                        wr_addr   = back_reg;
                        back_next = back_up;
                    end
                end
            end
            rbd_pkg::FUNC_POP_FRONT, rbd_pkg::FUNC_POP_BACK: begin
                if (empty) begin
                    status_next = rbd_pkg::ST_EMPTY;
                end else begin
                    rd_en       = cmd.exec;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (func == rbd_pkg::FUNC_POP_FRONT) begin
                        rd_addr    = front_reg;
                        front_next = front_up;
                    end else begin
                        rd_addr   = back_dn;
                        back_next = back_dn;
                    end
                end
            end
            default: status_next = rbd_pkg::ST_OK;
        endcase
    end

    // pointer and count state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // slot memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) slot_mem[wr_addr] <= WORD_BITS'(job_in);
        if (rd_en) rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // count is already post-operation when the result is formed
    always_comb begin
        res_new.status      = status_reg;
        res_new.job_out     = pop_ok_reg ? rbd_pkg::JOB_BITS'(rd_data_reg) : '0;
        res_new.entry_count = rbd_pkg::CNT_BITS'(count_reg);
        res_new.is_empty    = empty;
        res_new.is_full     = full;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) out_reg <= cmd.out_sel_skid ? skid_reg : res_new;
        if (cmd.skid_ld) skid_reg <= res_new;
    end

    assign res_out = out_reg;

endmodule

### rtl/ring_buffer_deque_top.sv
// ============================================================================
// ring_buffer_deque_top - double-ended queue in a circular slot memory
// Push/pop at either end; one result per operation with status and count.
// ============================================================================
//
//  channel  dir  tdata fields (lsb first)                          width
//  -------  ---  ------------------------------------------------  -----
//  s_       in   func[1:0], job_in[33:2], zero pad [39:34]            40
//  m_       out  status[1:0], job_out[33:2], entry_count[42:34],      48
//                is_empty[43], is_full[44], zero pad [47:45]
//
//  Each operation runs through S_IDLE and S_DONE: the accept cycle updates
//  pointers and count and issues the registered slot-memory read; the next
//  cycle forms the result, and no new input is taken until it has.
//  Reset (aresetn low, synchronous) empties the deque; slot contents are
//  not cleared and need not be, since only occupied slots are read.
//  An output register plus a one-entry skid register let the next input
//  transfer be taken while a result waits on m_tready.
//
module ring_buffer_deque_top #(
    parameter int DEPTH     = 256,  // slots, 2..511 (entry_count is 9 bits)
    parameter int WORD_BITS = 32    // stored bits per job word
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input: func[1:0], job_in[33:2]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rbd_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // result: status[1:0], job_out[33:2], entry_count[42:34],
    //         is_empty[43], is_full[44]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rbd_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    rbd_pkg::cmd_t  cmd;
    rbd_pkg::res_t  res;
    rbd_pkg::func_t func;
    logic [rbd_pkg::JOB_BITS-1:0] job_in;

    // unpack input fields
    assign func   = rbd_pkg::func_t'(s_tdata[rbd_pkg::FUNC_BITS-1:0]);
    assign job_in = s_tdata[rbd_pkg::FUNC_BITS +: rbd_pkg::JOB_BITS];

    rbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rbd_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .func    (func),
        .job_in  (job_in),
        .res_out (res)
    );

    // pad result record out to whole bytes
    assign m_tdata = rbd_pkg::M_TDATA_BITS'(res);

endmodule

### rtl/rbd_checker.sv
// ============================================================================
// rbd_checker - port-level assertions for ring_buffer_deque_top
// Watches both stream channels; attached to the top level by bind.
// ============================================================================
module rbd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [rbd_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rbd_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    // offered input holds until taken
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while waiting");

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no new input is taken while an operation forms its result
    a_two_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // refused pop: deque empty, no word returned
    a_refused_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == rbd_pkg::ST_EMPTY)
        |-> m_tdata[43] && (m_tdata[42:34] == '0) && (m_tdata[33:2] == '0))
        else $error("refused pop with entries or data");

endmodule

bind ring_buffer_deque_top rbd_checker u_rbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/tb_top.sv
// ============================================================================
// tb_top - self-checking bench for ring_buffer_deque_top
// Drives push/pop operations on the input stream in random bursts. Predicts
// each result with a deque model kept in the bench and compares every
// result field. The result side stalls on its own pattern, with long
// hold-offs that back up the block.
// ============================================================================
module tb_top;

    localparam int DEPTH       = 256;
    localparam int WORD_BITS   = 32;
    localparam int ITEM_TARGET = 1950;  // total operations offered
    localparam int IDLE_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 400;   // length of a long result-side hold-off
    localparam int DRAIN_WAIT  = 16;    // settle time after the last result

    localparam logic [rbd_pkg::JOB_BITS-1:0] WORD_MASK =
        (WORD_BITS >= rbd_pkg::JOB_BITS) ? '1 :
        ((rbd_pkg::JOB_BITS'(1) << WORD_BITS) - 1);

    // random segment shapes: runs that fill, runs that drain, and a mix
    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

    typedef struct {
        rbd_pkg::func_t               op;
        logic [rbd_pkg::JOB_BITS-1:0] word;
    } deque_op_t;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [rbd_pkg::S_TDATA_BITS-1:0]  s_tdata  = '0;  // func[1:0], job_in[33:2]
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [rbd_pkg::M_TDATA_BITS-1:0]  m_tdata;        // status[1:0], job_out[33:2],
                                                       // entry_count[42:34],
                                                       // is_empty[43], is_full[44]

    initial begin
        forever #5 aclk = ~aclk;
    end

    ring_buffer_deque_top #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Deque predictor: its own slot memory, pointers and occupancy
    // ------------------------------------------------------------------------
    logic [rbd_pkg::JOB_BITS-1:0] slot_mem [DEPTH];
    int                  front_idx = 0;  // slot of the front entry
    int                  back_idx  = 0;  // slot just past the back entry
    int                  occupancy = 0;

    deque_op_t      op_queue[$];     // operations waiting to be offered
    rbd_pkg::res_t  outcome_q[$];    // predicted results, oldest first
    int             fail_count   = 0;
    int             results_seen = 0;

    function automatic rbd_pkg::res_t apply_deque_op(rbd_pkg::func_t op,
                                                     logic [rbd_pkg::JOB_BITS-1:0] word);
        rbd_pkg::res_t r;
        r        = '0;
        r.status = rbd_pkg::ST_OK;
        case (op)
            rbd_pkg::FUNC_PUSH_FRONT, rbd_pkg::FUNC_PUSH_BACK: begin
                if (occupancy >= DEPTH) begin
                    r.status = rbd_pkg::ST_FULL;
                end else if (op == rbd_pkg::FUNC_PUSH_FRONT) begin
                    front_idx           = (front_idx + DEPTH - 1) % DEPTH;
                    slot_mem[front_idx] = word & WORD_MASK;
                    occupancy++;
                end else begin
                    slot_mem[back_idx] = word & WORD_MASK;
                    back_idx           = (back_idx + 1) % DEPTH;
                    occupancy++;
                end
            end
            default: begin
                if (occupancy == 0) begin
                    r.status = rbd_pkg::ST_EMPTY;
                end else if (op == rbd_pkg::FUNC_POP_FRONT) begin
                    r.job_out           = slot_mem[front_idx];
                    slot_mem[front_idx] = '0;
                    front_idx           = (front_idx + 1) % DEPTH;
                    occupancy--;
                end else begin
                    back_idx           = (back_idx + DEPTH - 1) % DEPTH;
                    r.job_out          = slot_mem[back_idx];
                    slot_mem[back_idx] = '0;
                    occupancy--;
                end
            end
        endcase
        r.entry_count = occupancy[rbd_pkg::CNT_BITS-1:0];
        r.is_empty    = (occupancy == 0);
        r.is_full     = (occupancy == DEPTH);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_op(rbd_pkg::func_t op, logic [rbd_pkg::JOB_BITS-1:0] word);
        deque_op_t item;
        item.op   = op;
        item.word = word;
        op_queue.push_back(item);
    endtask

    // mostly random words, with the all-zero and all-one extremes mixed in
    function automatic logic [rbd_pkg::JOB_BITS-1:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued operations in bursts separated by random gaps.
    // Prediction happens here, on the transfer itself, from the bus bits.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_ops
        deque_op_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_deque_op(
                    rbd_pkg::func_t'(s_tdata[rbd_pkg::FUNC_BITS-1:0]),
                    s_tdata[rbd_pkg::FUNC_BITS +: rbd_pkg::JOB_BITS]));
            // bus is free to change once the current item has transferred
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (op_queue.size() != 0) begin
                    nxt = op_queue.pop_front();
                    s_tdata  <= {{(rbd_pkg::S_TDATA_BITS - rbd_pkg::FUNC_BITS -
                                   rbd_pkg::JOB_BITS){1'b0}},
                                 nxt.word, nxt.op};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 48);
                        // a third of the bursts run straight into the next one
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: own stall pattern on m_tready, plus long hold-offs so the
    // block fills its output and skid registers and pushes back on s_tready.
    // ------------------------------------------------------------------------
    int hold_left  = 0;
    int next_hold  = 300;   // result count that triggers the next hold-off
    int pat_mode   = 0;
    int pat_left   = 0;
    int pat_tick   = 0;

    always @(posedge aclk) begin : watch_results
        rbd_pkg::res_t got;
        rbd_pkg::res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = rbd_pkg::res_t'(m_tdata[rbd_pkg::RES_BITS-1:0]);
                results_seen++;
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result transfer, tdata=%h", m_tdata);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status || got.job_out !== want.job_out ||
                        got.entry_count !== want.entry_count ||
                        got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: result %0d: status %0d/%0d job_out %h/%h ",
                                      "count %0d/%0d empty %0b/%0b full %0b/%0b (exp/got)"},
                                     results_seen, want.status, got.status,
                                     want.job_out, got.job_out,
                                     want.entry_count, got.entry_count,
                                     want.is_empty, got.is_empty,
                                     want.is_full, got.is_full);
                    end
                end
            end

            pat_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (results_seen >= next_hold) begin
                hold_left  = HOLD_CYCLES - 1;
                next_hold += 1000;
                m_tready  <= 1'b0;
            end else begin
                if (pat_left <= 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(40, 200);
                end
                pat_left--;
                case (pat_mode)
                    0:       m_tready <= 1'b1;                          // no stalls
                    1:       m_tready <= 1'($urandom_range(0, 1));      // coin flip
                    2:       m_tready <= pat_tick[0];                   // every other
                    default: m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if nothing transfers for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL ring_buffer_deque_top");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        seg_kind_t      seg;
        int             seg_no;
        int             len;
        int             push_pct;
        bit             is_push;
        bit             at_front;
        rbd_pkg::func_t op;

        // directed: empty pops, extreme words, order at both ends, wrap of
        // the front pointer below slot zero, pops that leave the deque empty
        add_op(rbd_pkg::FUNC_POP_FRONT,  32'hFFFF_FFFF);   // pop when empty, word ignored
        add_op(rbd_pkg::FUNC_POP_BACK,   32'h0000_0000);
        add_op(rbd_pkg::FUNC_PUSH_FRONT, 32'hFFFF_FFFF);   // front pointer wraps down
        add_op(rbd_pkg::FUNC_PUSH_BACK,  32'h0000_0000);
        add_op(rbd_pkg::FUNC_PUSH_FRONT, 32'h8000_0000);
        add_op(rbd_pkg::FUNC_POP_BACK,   32'h1234_5678);   // -> 0
        add_op(rbd_pkg::FUNC_POP_FRONT,  32'h0);           // -> 8000_0000
        add_op(rbd_pkg::FUNC_POP_FRONT,  32'h0);           // -> FFFF_FFFF, now empty
        add_op(rbd_pkg::FUNC_POP_BACK,   32'hDEAD_BEEF);   // pop when empty again
        add_op(rbd_pkg::FUNC_PUSH_BACK,  32'hA5A5_A5A5);
        add_op(rbd_pkg::FUNC_PUSH_BACK,  32'h5A5A_5A5A);
        add_op(rbd_pkg::FUNC_POP_FRONT,  32'h0);           // -> A5A5_A5A5
        add_op(rbd_pkg::FUNC_PUSH_FRONT, 32'h0000_0001);
        add_op(rbd_pkg::FUNC_POP_BACK,   32'h0);           // -> 5A5A_5A5A
        add_op(rbd_pkg::FUNC_POP_BACK,   32'h0);           // -> 0000_0001, via back
        add_op(rbd_pkg::FUNC_PUSH_BACK,  32'h7FFF_FFFE);
        add_op(rbd_pkg::FUNC_POP_FRONT,  32'hFFFF_FFFF);   // -> 7FFF_FFFE

        // random: first a fill to full and a drain to empty, then a mix of
        // segments; fill/drain runs are long enough to hit both limits
        seg_no = 0;
        while (op_queue.size() < ITEM_TARGET) begin
            if (seg_no == 0)
                seg = SEG_FILL;
            else if (seg_no == 1)
                seg = SEG_DRAIN;
            else
                seg = seg_kind_t'($urandom_range(0, 2));
            seg_no++;
            case (seg)
                SEG_FILL:  begin push_pct = 92; len = $urandom_range(330, 400); end
                SEG_DRAIN: begin push_pct = 8;  len = $urandom_range(330, 400); end
                default:   begin push_pct = 50; len = $urandom_range(16, 120);  end
            endcase
            if (len > ITEM_TARGET - op_queue.size())
                len = ITEM_TARGET - op_queue.size();
            for (int i = 0; i < len; i++) begin
                is_push  = ($urandom_range(0, 99) < push_pct);
                at_front = 1'($urandom_range(0, 1));
                if (is_push)
                    op = at_front ? rbd_pkg::FUNC_PUSH_FRONT : rbd_pkg::FUNC_PUSH_BACK;
                else
                    op = at_front ? rbd_pkg::FUNC_POP_FRONT : rbd_pkg::FUNC_POP_BACK;
                add_op(op, rand_word());
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // all operations transferred, then all results back
        while (op_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (outcome_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0 && outcome_q.size() == 0)
            $display("PASS ring_buffer_deque_top");
        else
            $display("FAIL ring_buffer_deque_top");
        $finish;
    end

endmodule

### filelist.f
rtl/rbd_pkg.sv
rtl/rbd_ctrl.sv
rtl/rbd_datapath.sv
rtl/ring_buffer_deque_top.sv
rtl/rbd_checker.sv
tb/tb_top.sv
